// File: rtl/can_node_alias_reservation_assert.svh
// assertion macros used by the rtl back end
`ifndef CAN_NODE_ALIAS_RESERVATION_ASSERT_SVH
`define CAN_NODE_ALIAS_RESERVATION_ASSERT_SVH

// implication checked on every clock edge outside reset
`define CNAR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define CNAR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/cnar_pkg.sv
package cnar_pkg;

   typedef enum logic [3:0] {
      PH_PICK   = 4'd0,
      PH_CID7   = 4'd1,
      PH_CID6   = 4'd2,
      PH_CID5   = 4'd3,
      PH_CID4   = 4'd4,
      PH_WAIT   = 4'd5,
      PH_RID    = 4'd6,
      PH_AMD    = 4'd7,
      PH_INIT   = 4'd8,
      PH_PERMIT = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      ENG_IDLE = 2'd0,
      ENG_SEED = 2'd1,
      ENG_DONE = 2'd2
   } eng_type;

   localparam logic [0:0] CSR_NODE_IDENTITY = 1'b0;
   localparam logic [0:0] CSR_PRESET_ALIAS  = 1'b1;

   localparam logic [28:0] ID_TOP      = 29'h1000_0000;
   localparam logic [28:0] ID_MSG      = 29'h0800_0000;
   localparam logic [28:0] ID_CID7     = 29'h0700_0000;
   localparam logic [28:0] ID_CID6     = 29'h0600_0000;
   localparam logic [28:0] ID_CID5     = 29'h0500_0000;
   localparam logic [28:0] ID_CID4     = 29'h0400_0000;
   localparam logic [28:0] ID_RID      = 29'h0070_0000;
   localparam logic [28:0] ID_AMD      = 29'h0070_1000;
   localparam logic [28:0] ID_AME      = 29'h0070_2000;
   localparam logic [28:0] ID_AMR      = 29'h0070_3000;
   localparam logic [28:0] ID_INIT     = 29'h0910_0000;
   localparam logic [28:0] ID_VAR_MASK = 29'h07FF_F000;
   localparam logic [2:0]  TYPE_CID4   = 3'd4;

   localparam logic [23:0] SEED_ADD_HI = 24'h1B0CA3;
   localparam logic [23:0] SEED_ADD_LO = 24'h7A4BA9;
   localparam logic [7:0]  STALL_TICKS = 8'd30;
   localparam logic [7:0]  WAIT_TICKS  = 8'd2;
   localparam logic [11:0] ALIAS_FALLBACK = 12'hFFF;
   localparam int unsigned RETRY_CAP   = 4096;

   typedef struct packed {
      logic [7:0]  tick_now;
      logic        tx_accepted;
      logic        rx_valid;
      logic        rx_extended;
      logic [28:0] rx_ident;
      logic [3:0]  rx_length;
      logic [63:0] rx_payload;
   } req_word_type;

   typedef struct packed {
      logic        rx_taken;
      logic        frame_ready;
      logic [28:0] frame_ident;
      logic [3:0]  frame_length;
      logic [63:0] frame_payload;
      logic [11:0] current_alias;
      logic        permitted;
   } rsp_word_type;

   // front-end classification of one pass, carried through the queue
   typedef struct packed {
      logic [7:0]  tick;
      logic        tx_accepted;
      logic        rx_valid;
      logic        rx_ignore;
      logic [11:0] src_alias;
      logic        is_cid;
      logic        ame_match;
   } cls_type;

   function automatic logic [47:0] next_seed(input logic [47:0] s);
      logic [23:0] lo, hi, t1, t2;
      logic [25:0] los;
      logic [23:0] his;
      begin
         lo  = s[23:0];
         hi  = s[47:24];
         t1  = {hi[14:0], lo[23:15]};
         t2  = {lo[14:0], 9'd0};
         his = hi + t1 + SEED_ADD_HI;
         los = {2'b0, lo} + {2'b0, t2} + {2'b0, SEED_ADD_LO};
         // low half can carry up to two into the high half
         his = his + {22'd0, los[25:24]};
         next_seed = {his, los[23:0]};
      end
   endfunction

   function automatic logic [11:0] seed_alias(input logic [47:0] s);
      seed_alias = s[47:36] ^ s[35:24] ^ s[23:12] ^ s[11:0];
   endfunction

endpackage

// File: rtl/cnar_if.sv
interface cnar_req_if import cnar_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface cnar_rsp_if import cnar_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface cnar_csr_if ();
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [47:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/cnar_front.sv
module cnar_front import cnar_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_word_type in_word,
   input  logic [47:0]  node_identity,
   output logic         q_valid,
   input  logic         q_ready,
   output cls_type      q_word
);

   // two-entry queue toward the back end
   cls_type     slot_ff [2];
   cls_type     slot_in;
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  count_ff;
   logic        push, pop;
   logic        is_type_cid;

   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_word   = slot_ff[rd_ptr_ff];

   assign is_type_cid = in_word.rx_ident[26:24] >= TYPE_CID4;

   always_comb begin
      slot_in.tick        = in_word.tick_now;
      slot_in.tx_accepted = in_word.tx_accepted;
      slot_in.rx_valid    = in_word.rx_valid;
      slot_in.rx_ignore   = !in_word.rx_extended || !in_word.rx_ident[28];
      slot_in.src_alias   = in_word.rx_ident[11:0];
      slot_in.is_cid      = !in_word.rx_ident[27] && is_type_cid;
      slot_in.ame_match   = !in_word.rx_ident[27]
         && ((in_word.rx_ident & ID_VAR_MASK) == ID_AME)
         && ((in_word.rx_length == 4'd0)
             || (in_word.rx_length == 4'd6
                 && in_word.rx_payload[63:16] == node_identity));
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// File: rtl/cnar_back.sv
`include "can_node_alias_reservation_assert.svh"
module cnar_back import cnar_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   output logic         q_ready,
   input  cls_type      q_word,
   input  logic [47:0]  node_identity,
   input  logic [11:0]  preset_alias,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_word_type out_word
);

   phase_type    phase_ff, phase_in;
   eng_type      eng_ff, eng_in;
   logic [47:0]  seed_ff, seed_in;
   logic [11:0]  alias_ff, alias_in;
   logic [7:0]   wait_ff, wait_in;
   logic [7:0]   txs_ff, txs_in;
   logic         pend_ff, pend_in;
   logic [12:0]  tries_ff, tries_in;
   logic         ov_ff;
   rsp_word_type ow_ff, ow_in;
   logic         finish;

   // per-pass scratch
   phase_type    ph1;
   logic         pend1, taken, q_en, q_with_id;
   logic [28:0]  q_id;
   logic [7:0]   tk;
   logic         need_seed;
   logic [47:0]  nseed;
   logic [11:0]  nalias;

   assign q_ready   = (eng_ff == ENG_IDLE) && (!ov_ff || out_ready);
   assign out_valid = ov_ff;
   assign out_word  = ow_ff;
   assign nseed     = next_seed(seed_ff);
   assign nalias    = seed_alias(nseed);

   // pass evaluation; seed search runs over extra cycles
   always_comb begin
      tk        = q_word.tick;
      ph1       = phase_ff;
      pend1     = pend_ff;
      taken     = 1'b0;
      q_en      = 1'b0;
      q_with_id = 1'b0;
      q_id      = 29'd0;
      need_seed = 1'b0;
      alias_in  = alias_ff;
      seed_in   = seed_ff;
      wait_in   = wait_ff;
      if (pend1) begin
         if (q_word.tx_accepted) pend1 = 1'b0;
         else if (ph1 != PH_PERMIT && (tk - txs_ff) > STALL_TICKS) begin
            pend1 = 1'b0;
            ph1   = PH_PICK;
         end
      end
      if (q_word.rx_valid) begin
         taken = 1'b1;
         if (!q_word.rx_ignore) begin
            if (q_word.src_alias == alias_ff && alias_ff != 12'd0) begin
               if (ph1 == PH_PERMIT) begin
                  if (pend1) taken = 1'b0;
                  else if (q_word.is_cid) begin
                     q_en = 1'b1; q_id = ID_TOP | ID_RID | {17'd0, alias_ff};
                  end else begin
                     q_en = 1'b1; q_with_id = 1'b1;
                     q_id = ID_TOP | ID_AMR | {17'd0, alias_ff};
                     ph1  = PH_PICK;
                  end
               end else ph1 = PH_PICK;
            end else if (q_word.ame_match && ph1 == PH_PERMIT) begin
               if (pend1) taken = 1'b0;
               else begin
                  q_en = 1'b1; q_with_id = 1'b1;
                  q_id = ID_TOP | ID_AMD | {17'd0, alias_ff};
               end
            end
         end
      end
      if (q_en) pend1 = 1'b1;
      if (ph1 != PH_PERMIT && !pend1) begin
         unique case (ph1)
            PH_PICK: begin
               if (alias_ff == 12'd0 && preset_alias != 12'd0) begin
                  alias_in = preset_alias;
                  ph1 = PH_CID7;
               end else if (alias_ff == 12'd0 && seed_alias(node_identity) != 12'd0) begin
                  seed_in  = node_identity;
                  alias_in = seed_alias(node_identity);
                  ph1 = PH_CID7;
               end else begin
                  if (alias_ff == 12'd0) seed_in = node_identity;
                  need_seed = 1'b1;
               end
            end
            PH_CID7: begin
               q_en = 1'b1; ph1 = PH_CID6;
               q_id = ID_TOP | ID_CID7 | {5'd0, node_identity[47:36], alias_ff};
            end
            PH_CID6: begin
               q_en = 1'b1; ph1 = PH_CID5;
               q_id = ID_TOP | ID_CID6 | {5'd0, node_identity[35:24], alias_ff};
            end
            PH_CID5: begin
               q_en = 1'b1; ph1 = PH_CID4;
               q_id = ID_TOP | ID_CID5 | {5'd0, node_identity[23:12], alias_ff};
            end
            PH_CID4: begin
               q_en = 1'b1; ph1 = PH_WAIT; wait_in = tk;
               q_id = ID_TOP | ID_CID4 | {5'd0, node_identity[11:0], alias_ff};
            end
            PH_WAIT: if ((tk - wait_ff) > WAIT_TICKS) ph1 = PH_RID;
            PH_RID: begin
               q_en = 1'b1; ph1 = PH_AMD;
               q_id = ID_TOP | ID_RID | {17'd0, alias_ff};
            end
            PH_AMD: begin
               q_en = 1'b1; q_with_id = 1'b1; ph1 = PH_INIT;
               q_id = ID_TOP | ID_AMD | {17'd0, alias_ff};
            end
            PH_INIT: begin
               q_en = 1'b1; q_with_id = 1'b1; ph1 = PH_PERMIT;
               q_id = ID_TOP | ID_INIT | {17'd0, alias_ff};
            end
            default: ph1 = ph1;
         endcase
      end
   end

   // engine control
   assign finish = (eng_ff == ENG_SEED)
      && (nalias != 12'd0 || tries_ff == 13'(RETRY_CAP - 1));

   always_comb begin
      eng_in = eng_ff;
      unique case (eng_ff)
         ENG_IDLE: if (q_valid && q_ready && need_seed) eng_in = ENG_SEED;
         ENG_SEED: if (finish) eng_in = ENG_DONE;
         ENG_DONE: if (!ov_ff || out_ready) eng_in = ENG_IDLE;
         default:  eng_in = ENG_IDLE;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      pend_in  = pend_ff;
      txs_in   = txs_ff;
      tries_in = tries_ff;
      ow_in    = ow_ff;
      if (eng_ff == ENG_IDLE && q_valid && q_ready) begin
         phase_in = ph1;
         pend_in  = pend1 || q_en;
         if (q_en) txs_in = tk;
         tries_in = 13'd0;
         ow_in.rx_taken      = taken;
         ow_in.frame_ready   = q_en;
         ow_in.frame_ident   = q_en ? q_id : 29'd0;
         ow_in.frame_length  = q_with_id ? 4'd6 : 4'd0;
         ow_in.frame_payload = q_with_id ? {node_identity, 16'd0} : 64'd0;
         ow_in.current_alias = alias_in;
         ow_in.permitted     = (ph1 == PH_PERMIT);
      end else if (eng_ff == ENG_SEED) begin
         tries_in = tries_ff + 13'd1;
         if (finish) begin
            phase_in = PH_CID7;
            ow_in.current_alias = (nalias == 12'd0) ? ALIAS_FALLBACK : nalias;
         end
      end
   end

   always_ff @(posedge clock) begin
      ow_ff    <= ow_in;
      tries_ff <= tries_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PICK;
         eng_ff   <= ENG_IDLE;
         seed_ff  <= 48'd0;
         alias_ff <= 12'd0;
         wait_ff  <= 8'd0;
         txs_ff   <= 8'd0;
         pend_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         eng_ff   <= eng_in;
         pend_ff  <= pend_in;
         txs_ff   <= txs_in;
         if (eng_ff == ENG_IDLE && q_valid && q_ready) begin
            seed_ff  <= seed_in;
            alias_ff <= alias_in;
            wait_ff  <= wait_in;
         end else if (eng_ff == ENG_SEED) begin
            seed_ff <= nseed;
            if (finish) alias_ff <= (nalias == 12'd0) ? ALIAS_FALLBACK : nalias;
         end
         if (eng_ff == ENG_IDLE && q_valid && q_ready) ov_ff <= !need_seed;
         else if (eng_ff == ENG_DONE && (!ov_ff || out_ready)) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
      end
   end

   `CNAR_ASSERT(a_no_take_in_search, clock, reset, eng_ff == ENG_SEED |-> !q_ready, "took a word during seed search")
   `CNAR_ASSERT(a_permit_alias, clock, reset, phase_ff == PH_PERMIT |-> alias_ff != 12'd0, "permitted with alias zero")
   `CNAR_ASSERT(a_search_ends_cid7, clock, reset, $past(finish) |-> phase_ff == PH_CID7, "seed search did not end in cid7")
   `CNAR_ASSERT(a_tries_bound, clock, reset, eng_ff == ENG_SEED |-> tries_ff < 13'(RETRY_CAP), "seed search overran")

endmodule

// File: rtl/can_node_alias_reservation.sv
// CAN node alias reservation: one request word is one service pass (tick, transmit
// acknowledge, optional received frame) and gives exactly one response word. A pass
// goes through a two-entry queue and the back end, whose output register holds its
// response; one pass per cycle while the response side keeps up and no seed search
// runs. A pass that must derive a new alias runs the seed generator one step per
// cycle until the alias is nonzero or the retry cap is reached (alias 12'hFFF then).
// Configuration is taken at once.
module can_node_alias_reservation import cnar_pkg::*; (
   input logic          clock,
   input logic          reset,
   cnar_req_if.sink     req,
   cnar_rsp_if.source   rsp,
   cnar_csr_if.sink     csr
);

   logic [47:0] node_identity_ff;
   logic [11:0] preset_alias_ff;
   logic        q_valid, q_ready;
   cls_type     q_word;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_identity_ff <= 48'd0;
         preset_alias_ff  <= 12'd0;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_NODE_IDENTITY: node_identity_ff <= csr.data;
            CSR_PRESET_ALIAS:  preset_alias_ff  <= csr.data[11:0];
            default: ;
         endcase
      end
   end

   cnar_front u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready), .in_word (req.word),
      .node_identity (node_identity_ff),
      .q_valid, .q_ready, .q_word
   );

   cnar_back u_back (
      .clock, .reset,
      .q_valid, .q_ready, .q_word,
      .node_identity (node_identity_ff),
      .preset_alias (preset_alias_ff),
      .out_valid (rsp.valid), .out_ready (rsp.ready), .out_word (rsp.word)
   );

endmodule
